FILE: src/cclm_pkg.sv
package cclm_pkg;

    // Fixed-point position of the binary point in the matrix coefficients.
    localparam int FRAC_BITS = 16;

    localparam int PIX_W   = 8;
    localparam int COEF_W  = 20;
    localparam int ROW_W   = 3 * COEF_W;
    localparam int PROD_W  = PIX_W + 1 + COEF_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int TAB_DEPTH = 1 << PIX_W;

    localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};
    localparam logic [PIX_W-1:0] PIX_MIN = '0;

    // Operation codes carried in the low bits of the input tuser.
    localparam logic [1:0] OP_PIXEL      = 2'd0;
    localparam logic [1:0] OP_WRITE_LIN  = 2'd1;
    localparam logic [1:0] OP_WRITE_TONE = 2'd2;

    // Table channel codes.
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_ROW_RED   = 2'd0;
    localparam logic [1:0] REG_ROW_GREEN = 2'd1;
    localparam logic [1:0] REG_ROW_BLUE  = 2'd2;

    // Identity coefficient and the identity rows loaded at reset.
    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << FRAC_BITS;
    localparam logic [ROW_W-1:0] ROW_RED_RESET   = ROW_W'(COEF_ONE);
    localparam logic [ROW_W-1:0] ROW_GREEN_RESET = ROW_W'(COEF_ONE) << COEF_W;
    localparam logic [ROW_W-1:0] ROW_BLUE_RESET  = ROW_W'(COEF_ONE) << (2 * COEF_W);

    // Stage advance strobes handed to the matrix rows.
    typedef struct packed {
        logic prod;
        logic sum;
    } cclm_stage_en_t;

endpackage

FILE: src/cclm_row.sv
module cclm_row
    import cclm_pkg::*;
(
    input  logic                 clk,
    input  cclm_stage_en_t       en,
    input  logic [PIX_W-1:0]     lin_red,
    input  logic [PIX_W-1:0]     lin_green,
    input  logic [PIX_W-1:0]     lin_blue,
    input  logic [ROW_W-1:0]     row,
    output logic [PIX_W-1:0]     level
);

    logic signed [PROD_W-1:0] prod_reg  [3];
    logic signed [PROD_W-1:0] prod_next [3];
    logic signed [SUM_W-1:0]  sum;
    logic [PIX_W-1:0]         level_reg;
    logic [PIX_W-1:0]         level_next;
    logic signed [PIX_W:0]    lin_s [3];
    logic signed [COEF_W-1:0] coef_s [3];

    always_comb
    begin
        lin_s[0] = signed'({1'b0, lin_red});
        lin_s[1] = signed'({1'b0, lin_green});
        lin_s[2] = signed'({1'b0, lin_blue});
        for (int k = 0; k < 3; k++)
        begin
            coef_s[k]    = signed'(row[k*COEF_W +: COEF_W]);
            prod_next[k] = PROD_W'(lin_s[k] * coef_s[k]);
        end
    end

    // Sum the three products, drop the fraction and clamp to the pixel range.
    always_comb
    begin
        sum = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2]);
        if (sum[SUM_W-1])
            level_next = PIX_MIN;
        else if (|sum[SUM_W-2:FRAC_BITS+PIX_W])
            level_next = PIX_MAX;
        else
            level_next = sum[FRAC_BITS +: PIX_W];
    end

    always_ff @(posedge clk)
    begin
        if (en.prod)
        begin
            prod_reg <= prod_next;
        end
        if (en.sum)
        begin
            level_reg <= level_next;
        end
    end

    assign level = level_reg;

endmodule

FILE: src/color_correction_lut_matrix_top.sv
// Colour correction: linearisation tables, 3x3 matrix, tone-response tables.
// Pipeline: a pixel beat passes the registered stages linear table read,
// multiply, sum and clamp, and tone table read before it raises m_tvalid.
// Throughput: one beat per clock while m_tready does not stall the output,
// set by the table ports and the per-row multiply stage; every stage has its
// own valid and fills bubbles.
// Reset clears the pipeline valids and loads the identity matrix; the tables
// are not cleared and hold nothing meaningful until they are written.
module color_correction_lut_matrix_top
    import cclm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // Input stream.
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [39:0]       s_tdata,   // entry_index, entry_value, red_in, green_in, blue_in
    input  logic [3:0]        s_tuser,   // operation, channel
    // Output stream.
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // red_out, green_out, blue_out
    // Configuration writes.
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [ROW_W-1:0]  cfg_data
);

    // What travels beside the pixel data: tone table writes go down the
    // pipeline so that they land in order with the pixels around them.
    typedef struct packed {
        logic              is_pixel;
        logic [1:0]        channel;
        logic [PIX_W-1:0]  index;
        logic [PIX_W-1:0]  value;
    } meta_t;

    // Unpacked input beat.
    logic [1:0]       in_op;
    logic [1:0]       in_channel;
    logic [PIX_W-1:0] in_index;
    logic [PIX_W-1:0] in_value;
    logic [PIX_W-1:0] in_red;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_blue;
    logic             in_accept;
    logic             in_keep;

    assign in_op      = s_tuser[1:0];
    assign in_channel = s_tuser[3:2];
    assign in_index   = s_tdata[7:0];
    assign in_value   = s_tdata[15:8];
    assign in_red     = s_tdata[23:16];
    assign in_green   = s_tdata[31:24];
    assign in_blue    = s_tdata[39:32];

    // Matrix rows.
    logic [ROW_W-1:0] row_red_reg;
    logic [ROW_W-1:0] row_green_reg;
    logic [ROW_W-1:0] row_blue_reg;

    // Pipeline control.
    logic  v1_reg, v2_reg, v3_reg, v4_reg;
    logic  adv1, adv2, adv3, adv4;
    meta_t meta1_reg, meta2_reg, meta3_reg;
    cclm_stage_en_t row_en;

    // Tables.
    logic [PIX_W-1:0] lin_red_mem   [TAB_DEPTH];
    logic [PIX_W-1:0] lin_green_mem [TAB_DEPTH];
    logic [PIX_W-1:0] lin_blue_mem  [TAB_DEPTH];
    logic [PIX_W-1:0] tone_red_mem   [TAB_DEPTH];
    logic [PIX_W-1:0] tone_green_mem [TAB_DEPTH];
    logic [PIX_W-1:0] tone_blue_mem  [TAB_DEPTH];

    logic [PIX_W-1:0] lin_red_reg, lin_green_reg, lin_blue_reg;
    logic [PIX_W-1:0] out_red_reg, out_green_reg, out_blue_reg;
    logic [PIX_W-1:0] level_red, level_green, level_blue;
    logic [2:0]       lin_we;
    logic [2:0]       tone_we;

    // Each stage moves on when it is empty or the stage after it moves.
    assign adv4 = !v4_reg || m_tready;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    assign s_tready  = adv1;
    assign in_accept = s_tvalid && s_tready;

    // Only pixels and tone writes to a real channel go on down the pipe;
    // linear writes are finished at the input and code three is dropped.
    assign in_keep = (in_op == OP_PIXEL)
                  || ((in_op == OP_WRITE_TONE) && (in_channel <= CH_BLUE));

    assign row_en.prod = adv2;
    assign row_en.sum  = adv3;

    // Configuration is taken at any time; the user writes it only when idle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_red_reg   <= ROW_RED_RESET;
            row_green_reg <= ROW_GREEN_RESET;
            row_blue_reg  <= ROW_BLUE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ROW_RED:   row_red_reg   <= cfg_data;
                REG_ROW_GREEN: row_green_reg <= cfg_data;
                REG_ROW_BLUE:  row_blue_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Linear table write strobes, decoded from the input beat.
    always_comb
    begin
        lin_we = '0;
        if (in_accept && (in_op == OP_WRITE_LIN))
        begin
            unique case (in_channel)
                CH_RED:   lin_we[0] = 1'b1;
                CH_GREEN: lin_we[1] = 1'b1;
                CH_BLUE:  lin_we[2] = 1'b1;
                default:  ;
            endcase
        end
    end

    // Tone table writes happen at the same stage as tone reads, so a write
    // affects exactly the pixels that follow it on the input.
    always_comb
    begin
        tone_we = '0;
        if (v3_reg && adv4 && !meta3_reg.is_pixel)
        begin
            unique case (meta3_reg.channel)
                CH_RED:   tone_we[0] = 1'b1;
                CH_GREEN: tone_we[1] = 1'b1;
                CH_BLUE:  tone_we[2] = 1'b1;
                default:  ;
            endcase
        end
    end

    // Linear tables: written from the input, read into stage one. A read on
    // the same edge as a write sees the old entry, which matches beat order.
    always_ff @(posedge clk)
    begin
        if (lin_we[0])
        begin
            lin_red_mem[in_index] <= in_value;
        end
        if (lin_we[1])
        begin
            lin_green_mem[in_index] <= in_value;
        end
        if (lin_we[2])
        begin
            lin_blue_mem[in_index] <= in_value;
        end
        if (adv1)
        begin
            lin_red_reg   <= lin_red_mem[in_red];
            lin_green_reg <= lin_green_mem[in_green];
            lin_blue_reg  <= lin_blue_mem[in_blue];
        end
    end

    // Tone tables: written and read between stage three and the output.
    always_ff @(posedge clk)
    begin
        if (tone_we[0])
        begin
            tone_red_mem[meta3_reg.index] <= meta3_reg.value;
        end
        if (tone_we[1])
        begin
            tone_green_mem[meta3_reg.index] <= meta3_reg.value;
        end
        if (tone_we[2])
        begin
            tone_blue_mem[meta3_reg.index] <= meta3_reg.value;
        end
        if (adv4)
        begin
            out_red_reg   <= tone_red_mem[level_red];
            out_green_reg <= tone_green_mem[level_green];
            out_blue_reg  <= tone_blue_mem[level_blue];
        end
    end

    // Stage valids.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_accept && in_keep;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
            if (adv4)
            begin
                v4_reg <= v3_reg && meta3_reg.is_pixel;
            end
        end
    end

    // Side information, no reset needed.
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            meta1_reg.is_pixel <= (in_op == OP_PIXEL);
            meta1_reg.channel  <= in_channel;
            meta1_reg.index    <= in_index;
            meta1_reg.value    <= in_value;
        end
        if (adv2)
        begin
            meta2_reg <= meta1_reg;
        end
        if (adv3)
        begin
            meta3_reg <= meta2_reg;
        end
    end

    // One matrix row per output channel: multiply stage, then sum and clamp.
    cclm_row u_row_red
    (
        .clk       (clk),
        .en        (row_en),
        .lin_red   (lin_red_reg),
        .lin_green (lin_green_reg),
        .lin_blue  (lin_blue_reg),
        .row       (row_red_reg),
        .level     (level_red)
    );

    cclm_row u_row_green
    (
        .clk       (clk),
        .en        (row_en),
        .lin_red   (lin_red_reg),
        .lin_green (lin_green_reg),
        .lin_blue  (lin_blue_reg),
        .row       (row_green_reg),
        .level     (level_green)
    );

    cclm_row u_row_blue
    (
        .clk       (clk),
        .en        (row_en),
        .lin_red   (lin_red_reg),
        .lin_green (lin_green_reg),
        .lin_blue  (lin_blue_reg),
        .row       (row_blue_reg),
        .level     (level_blue)
    );

    assign m_tvalid = v4_reg;
    assign m_tdata  = {out_blue_reg, out_green_reg, out_red_reg};

`ifndef SYNTHESIS
    // A result only appears when a pixel sat in stage three the cycle before.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(v3_reg && meta3_reg.is_pixel))
        else $error("output beat appeared without a pixel behind it");

    // A stalled stage three keeps its item and its clamped levels.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !adv4) |=> (v3_reg && $stable(level_red)
                               && $stable(level_green) && $stable(level_blue)))
        else $error("stage three lost its item under back-pressure");

    // A linear table write ends at the input and never enters the pipeline.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (in_op == OP_WRITE_LIN)) |=> !v1_reg)
        else $error("linear table write entered the pipeline");
`endif

endmodule
